>>> sv/erfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erfc_pkg
// Shared widths, Q30 constants and the pipeline word type of the erfc unit.
// ----------------------------------------------------------------------------
package erfc_pkg;

    localparam int ARG_W             = 16;
    localparam int RES_W             = 16;
    localparam int MAG_W             = ARG_W + 1;
    localparam int Q_FRAC            = 30;
    localparam int Q_W               = Q_FRAC + 1;
    localparam int DEF_IN_FRAC_BITS  = 12;
    localparam int DEF_OUT_FRAC_BITS = 14;
    localparam int EXP_TERMS         = 16;
    localparam int SQ_LIMIT          = 32;
    localparam int N_W               = $clog2(SQ_LIMIT) + 1;
    localparam int POW_STAGES        = SQ_LIMIT;
    localparam int DIV_STEPS         = Q_W;
    localparam int HORNER_STEPS      = 5;

    localparam longint ONE_Q30  = longint'(1) << Q_FRAC;
    localparam longint HALF_Q30 = longint'(1) << (Q_FRAC - 1);

    function automatic longint to_q30(input longint c9);
        longint m;
        longint r;
        m = (c9 < 0) ? -c9 : c9;
        r = ((m << Q_FRAC) + 64'sd500000000) / 64'sd1000000000;
        return (c9 < 0) ? -r : r;
    endfunction

    localparam longint COEF_A1 = to_q30(64'sd254829592);
    localparam longint COEF_A2 = to_q30(-64'sd284496736);
    localparam longint COEF_A3 = to_q30(64'sd1421413741);
    localparam longint COEF_A4 = to_q30(-64'sd1453152027);
    localparam longint COEF_A5 = to_q30(64'sd1061405429);
    localparam longint COEF_P  = to_q30(64'sd327591100);

    localparam longint HORNER_ADD [HORNER_STEPS-1] = '{COEF_A4, COEF_A3, COEF_A2, COEF_A1};

    // exp(-1) by the same rounded 16-term series the datapath uses
    localparam longint E1_Q30 = 64'sd395007542;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [Q_W-1:0]   e;
        logic [Q_W-1:0]   t;
        logic [Q_W-1:0]   acc;
    } item_t;

endpackage

>>> sv/erfc_polynomial_approx.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erfc_polynomial_approx
// Complementary error function of a signed fixed-point argument by a
// five-term rational polynomial times exp(-x^2), unsigned result to 2.0.
//
//   channel  dir  fields (lsb first)
//   s_       in   tdata[15:0] arg_value, signed Q4.12
//   m_       out  tdata[15:0] erfc_value, unsigned Q2.14
//
// One word accepted per cycle unless the output stalls; a word passes the
// input register, the exp series and power stages, the one-bit-per-stage
// divider, the Horner stages and the product and output registers. A single
// enable advances every stage; while a word waits in the output register
// every stage holds and s_tready is low. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module erfc_polynomial_approx
    import erfc_pkg::*;
#(
    parameter int IN_FRAC_BITS  = DEF_IN_FRAC_BITS,
    parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [ARG_W-1:0] s_tdata,   // arg_value
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [RES_W-1:0] m_tdata    // erfc_value
);

    localparam int     OUT_SHIFT = Q_FRAC - OUT_FRAC_BITS;
    localparam int     R_W       = Q_W + 2;
    localparam int     PW        = 2 * Q_W;
    localparam longint RES_MAX   = (longint'(1) << RES_W) - 1;

    logic en;
    logic m_tvalid_reg;
    logic [RES_W-1:0] m_tdata_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // absolute value
    logic  in_valid_reg;
    item_t in_item_reg;
    item_t in_item;

    always_comb begin
        in_item     = '0;
        in_item.neg = s_tdata[ARG_W-1];
        in_item.mag = s_tdata[ARG_W-1] ? (MAG_W'(1) << ARG_W) - MAG_W'(s_tdata)
                                       : MAG_W'(s_tdata);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_item_reg <= in_item;
        end
    end

    logic  ex_valid;
    item_t ex_item;
    logic  rc_valid;
    item_t rc_item;
    logic  hn_valid;
    item_t hn_item;

    erfc_exp #(
        .IN_FRAC_BITS(IN_FRAC_BITS)
    ) u_exp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (in_valid_reg),
        .in_item  (in_item_reg),
        .out_valid(ex_valid),
        .out_item (ex_item)
    );

    erfc_recip #(
        .IN_FRAC_BITS(IN_FRAC_BITS)
    ) u_recip (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (ex_valid),
        .in_item  (ex_item),
        .out_valid(rc_valid),
        .out_item (rc_item)
    );

    erfc_horner u_horner (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (rc_valid),
        .in_item  (rc_item),
        .out_valid(hn_valid),
        .out_item (hn_item)
    );

    // polynomial times exp(-x^2)
    logic          fp_valid_reg;
    logic          fp_neg_reg;
    logic [PW-1:0] fp_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fp_valid_reg <= 1'b0;
        end else if (en) begin
            fp_valid_reg <= hn_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fp_neg_reg  <= hn_item.neg;
            fp_prod_reg <= PW'(hn_item.acc) * PW'(hn_item.e) + PW'(HALF_Q30);
        end
    end

    // reflect, round and saturate
    logic [Q_W-1:0] y_raw;
    logic [Q_W-1:0] y;
    logic [R_W-1:0] r;
    logic [R_W-1:0] res;
    logic [R_W-1:0] res_next;

    assign y_raw = fp_prod_reg[Q_FRAC+Q_W-1:Q_FRAC];
    assign y     = (y_raw > Q_W'(ONE_Q30)) ? Q_W'(ONE_Q30) : y_raw;
    assign r     = fp_neg_reg ? R_W'(2 * ONE_Q30) - R_W'(y) : R_W'(y);
    assign res   = (r + (R_W'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT;

    always_comb begin
        res_next = res;
        if (res_next > (R_W'(2) << OUT_FRAC_BITS)) begin
            res_next = R_W'(2) << OUT_FRAC_BITS;
        end
        if (res_next > R_W'(RES_MAX)) begin
            res_next = R_W'(RES_MAX);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= fp_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= res_next[RES_W-1:0];
        end
    end

endmodule

>>> sv/erfc_exp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erfc_exp
// exp(-x^2) in Q30: split into integer and fraction, series for the fraction,
// then one multiply by exp(-1) per stage for the integer part.
// ----------------------------------------------------------------------------
module erfc_exp
    import erfc_pkg::*;
#(
    parameter int IN_FRAC_BITS = DEF_IN_FRAC_BITS
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  item_t in_item,
    output logic  out_valid,
    output item_t out_item
);

    localparam int SQ_FRAC = 2 * IN_FRAC_BITS;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int S30_W   = Q_FRAC + N_W;
    localparam int PW      = 2 * Q_W;
    localparam int SUM_W   = Q_W + 2;

    typedef struct packed {
        item_t             item;
        logic [Q_FRAC-1:0] f;
        logic [N_W-1:0]    n;
        logic              zero;
    } ctx_t;

    logic [SQ_W-1:0] sq;
    logic [63:0]     sq_ext;
    logic [63:0]     s30;
    logic            zero;

    assign sq     = SQ_W'(in_item.mag) * SQ_W'(in_item.mag);
    assign sq_ext = 64'(sq);
    assign zero   = sq_ext >= (64'(SQ_LIMIT) << SQ_FRAC);

    if (SQ_FRAC <= Q_FRAC) begin : g_up
        assign s30 = sq_ext << (Q_FRAC - SQ_FRAC);
    end else begin : g_dn
        assign s30 = (sq_ext + (64'd1 << (SQ_FRAC - Q_FRAC - 1))) >> (SQ_FRAC - Q_FRAC);
    end

    logic e0_valid_reg;
    ctx_t e0_ctx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e0_valid_reg <= 1'b0;
        end else if (en) begin
            e0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e0_ctx_reg.item <= in_item;
            e0_ctx_reg.f    <= s30[Q_FRAC-1:0];
            e0_ctx_reg.n    <= s30[S30_W-1:Q_FRAC];
            e0_ctx_reg.zero <= zero;
        end
    end

    // series for exp(-f)
    logic                    t_valid [0:EXP_TERMS];
    ctx_t                    t_ctx   [0:EXP_TERMS];
    logic [Q_W-1:0]          t_term  [0:EXP_TERMS];
    logic signed [SUM_W-1:0] t_sum   [0:EXP_TERMS];

    logic                    ta_valid_reg [1:EXP_TERMS];
    ctx_t                    ta_ctx_reg   [1:EXP_TERMS];
    logic [Q_W-1:0]          ta_pm_reg    [1:EXP_TERMS];
    logic signed [SUM_W-1:0] ta_sum_reg   [1:EXP_TERMS];
    logic                    tb_valid_reg [1:EXP_TERMS];
    ctx_t                    tb_ctx_reg   [1:EXP_TERMS];
    logic [Q_W-1:0]          tb_term_reg  [1:EXP_TERMS];
    logic signed [SUM_W-1:0] tb_sum_reg   [1:EXP_TERMS];

    assign t_valid[0] = e0_valid_reg;
    assign t_ctx[0]   = e0_ctx_reg;
    assign t_term[0]  = Q_W'(ONE_Q30);
    assign t_sum[0]   = SUM_W'(ONE_Q30);

    for (genvar k = 1; k <= EXP_TERMS; k++) begin : g_term
        localparam int             L      = $clog2(k);
        localparam int             S      = Q_W + L;
        localparam longint         M      = ((longint'(1) << S) + k - 1) / k;
        localparam logic [Q_W:0]   RECIP  = (Q_W + 1)'(M);
        localparam logic [Q_W-1:0] HALF_K = Q_W'(k / 2);
        localparam bit             ODD    = (k % 2) == 1;

        logic [PW-1:0]   prod;
        logic [Q_W-1:0]  x;
        logic [PW:0]     qprod;
        logic [Q_W-1:0]  q;

        assign prod  = PW'(t_term[k-1]) * PW'(t_ctx[k-1].f) + PW'(HALF_Q30);
        assign x     = ta_pm_reg[k] + HALF_K;
        assign qprod = (PW + 1)'(x) * (PW + 1)'(RECIP);
        assign q     = Q_W'(qprod >> S);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ta_valid_reg[k] <= 1'b0;
                tb_valid_reg[k] <= 1'b0;
            end else if (en) begin
                ta_valid_reg[k] <= t_valid[k-1];
                tb_valid_reg[k] <= ta_valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ta_ctx_reg[k] <= t_ctx[k-1];
                ta_pm_reg[k]  <= prod[Q_FRAC+Q_W-1:Q_FRAC];
                ta_sum_reg[k] <= t_sum[k-1];
                tb_ctx_reg[k] <= ta_ctx_reg[k];
                tb_term_reg[k] <= q;
                if (ODD) begin
                    tb_sum_reg[k] <= ta_sum_reg[k] - $signed({2'b00, q});
                end else begin
                    tb_sum_reg[k] <= ta_sum_reg[k] + $signed({2'b00, q});
                end
            end
        end

        assign t_valid[k] = tb_valid_reg[k];
        assign t_ctx[k]   = tb_ctx_reg[k];
        assign t_term[k]  = tb_term_reg[k];
        assign t_sum[k]   = tb_sum_reg[k];
    end

    logic [Q_W-1:0] frac_exp;

    always_comb begin
        if (t_sum[EXP_TERMS] < 0) begin
            frac_exp = '0;
        end else if (t_sum[EXP_TERMS] > SUM_W'(ONE_Q30)) begin
            frac_exp = Q_W'(ONE_Q30);
        end else begin
            frac_exp = t_sum[EXP_TERMS][Q_W-1:0];
        end
    end

    // integer part: times exp(-1) while the stage index is below n
    logic           p_valid [0:POW_STAGES];
    ctx_t           p_ctx   [0:POW_STAGES];
    logic [Q_W-1:0] p_res   [0:POW_STAGES];

    logic           pw_valid_reg [1:POW_STAGES];
    ctx_t           pw_ctx_reg   [1:POW_STAGES];
    logic [Q_W-1:0] pw_res_reg   [1:POW_STAGES];

    assign p_valid[0] = t_valid[EXP_TERMS];
    assign p_ctx[0]   = t_ctx[EXP_TERMS];
    assign p_res[0]   = frac_exp;

    for (genvar i = 0; i < POW_STAGES; i++) begin : g_pow
        localparam logic [N_W-1:0] IDX = N_W'(i);
        logic [PW-1:0] pprod;

        assign pprod = PW'(p_res[i]) * PW'(E1_Q30) + PW'(HALF_Q30);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                pw_valid_reg[i+1] <= 1'b0;
            end else if (en) begin
                pw_valid_reg[i+1] <= p_valid[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                pw_ctx_reg[i+1] <= p_ctx[i];
                if (IDX < p_ctx[i].n) begin
                    pw_res_reg[i+1] <= pprod[Q_FRAC+Q_W-1:Q_FRAC];
                end else begin
                    pw_res_reg[i+1] <= p_res[i];
                end
            end
        end

        assign p_valid[i+1] = pw_valid_reg[i+1];
        assign p_ctx[i+1]   = pw_ctx_reg[i+1];
        assign p_res[i+1]   = pw_res_reg[i+1];
    end

    assign out_valid = p_valid[POW_STAGES];

    always_comb begin
        out_item   = p_ctx[POW_STAGES].item;
        out_item.e = p_ctx[POW_STAGES].zero ? '0 : p_res[POW_STAGES];
    end

endmodule

>>> sv/erfc_recip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erfc_recip
// t = 1 / (1 + p*|x|) in Q30, rounded, by a restoring divider with one
// quotient bit per stage.
// ----------------------------------------------------------------------------
module erfc_recip
    import erfc_pkg::*;
#(
    parameter int IN_FRAC_BITS = DEF_IN_FRAC_BITS
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  item_t in_item,
    output logic  out_valid,
    output item_t out_item
);

    localparam int PROD_W  = MAG_W + Q_W;
    localparam int DEN_RAW = MAG_W + Q_W - IN_FRAC_BITS - 1;
    localparam int DEN_W   = (DEN_RAW > Q_W + 1) ? DEN_RAW : Q_W + 1;
    localparam int NUM_W   = 2 * Q_FRAC + 2;

    localparam logic [PROD_W-1:0] PQ  = PROD_W'(COEF_P);
    localparam logic [PROD_W-1:0] RND = PROD_W'(1) << (IN_FRAC_BITS - 1);

    logic [PROD_W-1:0] pa;
    logic [DEN_W-1:0]  den;

    assign pa  = PQ * PROD_W'(in_item.mag) + RND;
    assign den = DEN_W'(ONE_Q30) + DEN_W'(pa >> IN_FRAC_BITS);

    logic             r0_valid_reg;
    item_t            r0_item_reg;
    logic [DEN_W-1:0] r0_den_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r0_valid_reg <= 1'b0;
        end else if (en) begin
            r0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r0_item_reg <= in_item;
            r0_den_reg  <= den;
        end
    end

    logic [NUM_W-1:0] num;

    assign num = (NUM_W'(1) << (2 * Q_FRAC)) + NUM_W'(r0_den_reg >> 1);

    logic                 dv_valid_reg [0:DIV_STEPS];
    item_t                dv_item_reg  [0:DIV_STEPS];
    logic [DEN_W-1:0]     dv_den_reg   [0:DIV_STEPS];
    logic [DEN_W-1:0]     dv_rem_reg   [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] dv_low_reg   [0:DIV_STEPS];
    logic [Q_W-1:0]       dv_quo_reg   [0:DIV_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_valid_reg[0] <= 1'b0;
        end else if (en) begin
            dv_valid_reg[0] <= r0_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_item_reg[0] <= r0_item_reg;
            dv_den_reg[0]  <= r0_den_reg;
            dv_rem_reg[0]  <= DEN_W'(num >> DIV_STEPS);
            dv_low_reg[0]  <= num[DIV_STEPS-1:0];
            dv_quo_reg[0]  <= '0;
        end
    end

    for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;

        assign trial = {dv_rem_reg[j-1], dv_low_reg[j-1][DIV_STEPS-1]};
        assign diff  = trial - {1'b0, dv_den_reg[j-1]};
        assign ge    = trial >= {1'b0, dv_den_reg[j-1]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[j] <= 1'b0;
            end else if (en) begin
                dv_valid_reg[j] <= dv_valid_reg[j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_item_reg[j] <= dv_item_reg[j-1];
                dv_den_reg[j]  <= dv_den_reg[j-1];
                dv_rem_reg[j]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                dv_low_reg[j]  <= dv_low_reg[j-1] << 1;
                dv_quo_reg[j]  <= {dv_quo_reg[j-1][Q_W-2:0], ge};
            end
        end
    end

    assign out_valid = dv_valid_reg[DIV_STEPS];

    always_comb begin
        out_item   = dv_item_reg[DIV_STEPS];
        out_item.t = dv_quo_reg[DIV_STEPS];
    end

endmodule

>>> sv/erfc_horner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erfc_horner
// Five-coefficient Horner evaluation in t, Q30 signed, two stages per step;
// the last step clamps the polynomial to [0, 1].
// ----------------------------------------------------------------------------
module erfc_horner
    import erfc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  item_t in_item,
    output logic  out_valid,
    output item_t out_item
);

    localparam int ACC_W = Q_W + 3;
    localparam int MAG_A = ACC_W - 1;
    localparam int PW    = MAG_A + Q_W;

    logic                    h_valid [0:HORNER_STEPS];
    item_t                   h_item  [0:HORNER_STEPS];
    logic signed [ACC_W-1:0] h_acc   [0:HORNER_STEPS];

    logic                    ha_valid_reg [1:HORNER_STEPS];
    item_t                   ha_item_reg  [1:HORNER_STEPS];
    logic                    ha_neg_reg   [1:HORNER_STEPS];
    logic [PW-1:0]           ha_prod_reg  [1:HORNER_STEPS];
    logic                    hb_valid_reg [1:HORNER_STEPS];
    item_t                   hb_item_reg  [1:HORNER_STEPS];
    logic signed [ACC_W-1:0] hb_acc_reg   [1:HORNER_STEPS];

    assign h_valid[0] = in_valid;
    assign h_item[0]  = in_item;
    assign h_acc[0]   = ACC_W'(COEF_A5);

    for (genvar j = 1; j <= HORNER_STEPS; j++) begin : g_step
        logic                    neg;
        logic [MAG_A-1:0]        mag;
        logic [MAG_A-1:0]        rnd;
        logic signed [ACC_W-1:0] prod_s;

        assign neg    = h_acc[j-1][ACC_W-1];
        assign mag    = neg ? MAG_A'(-h_acc[j-1]) : MAG_A'(h_acc[j-1]);
        assign rnd    = ha_prod_reg[j][Q_FRAC+MAG_A-1:Q_FRAC];
        assign prod_s = ha_neg_reg[j] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ha_valid_reg[j] <= 1'b0;
                hb_valid_reg[j] <= 1'b0;
            end else if (en) begin
                ha_valid_reg[j] <= h_valid[j-1];
                hb_valid_reg[j] <= ha_valid_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ha_item_reg[j] <= h_item[j-1];
                ha_neg_reg[j]  <= neg;
                ha_prod_reg[j] <= PW'(mag) * PW'(h_item[j-1].t) + PW'(HALF_Q30);
                hb_item_reg[j] <= ha_item_reg[j];
            end
        end

        if (j < HORNER_STEPS) begin : g_add
            always_ff @(posedge aclk) begin
                if (en) begin
                    hb_acc_reg[j] <= prod_s + ACC_W'(HORNER_ADD[j-1]);
                end
            end
        end else begin : g_clamp
            always_ff @(posedge aclk) begin
                if (en) begin
                    if (prod_s < 0) begin
                        hb_acc_reg[j] <= '0;
                    end else if (prod_s > ACC_W'(ONE_Q30)) begin
                        hb_acc_reg[j] <= ACC_W'(ONE_Q30);
                    end else begin
                        hb_acc_reg[j] <= prod_s;
                    end
                end
            end
        end

        assign h_valid[j] = hb_valid_reg[j];
        assign h_item[j]  = hb_item_reg[j];
        assign h_acc[j]   = hb_acc_reg[j];
    end

    assign out_valid = h_valid[HORNER_STEPS];

    always_comb begin
        out_item     = h_item[HORNER_STEPS];
        out_item.acc = h_acc[HORNER_STEPS][Q_W-1:0];
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams signed Q4.12 arguments into the erfc unit and checks every result
// word against a bit-exact integer model of the rational approximation.
// ----------------------------------------------------------------------------
module testbench;
    import erfc_pkg::*;

    localparam int  IN_FB     = 12;
    localparam int  OUT_FB    = 14;
    localparam int  N_RANDOM  = 1200;
    localparam int  LATENCY   = 111;
    localparam longint CYCLE_LIMIT = 400000;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [ARG_W-1:0] s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [RES_W-1:0] m_tdata;

    logic [ARG_W-1:0] arg_queue[$];
    logic [RES_W-1:0] erfc_expected[$];
    longint cycle_count = 0;
    int     error_count = 0;
    int     words_sent = 0;
    int     words_checked = 0;
    bit     stim_done = 1'b0;
    bit     calm_phase = 1'b0;

    erfc_polynomial_approx #(
        .IN_FRAC_BITS (IN_FB),
        .OUT_FRAC_BITS(OUT_FB)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic longint coef_fixed(input longint c9);
        longint m;
        longint r;
        m = (c9 < 0) ? -c9 : c9;
        r = ((m << 30) + 500000000) / 1000000000;
        return (c9 < 0) ? -r : r;
    endfunction

    function automatic longint fix_mul(input longint v, input longint t);
        longint m;
        longint r;
        m = (v < 0) ? -v : v;
        r = (m * t + (longint'(1) << 29)) >>> 30;
        return (v < 0) ? -r : r;
    endfunction

    function automatic longint fix_div(input longint v, input longint k);
        longint m;
        longint r;
        m = (v < 0) ? -v : v;
        r = (m + k / 2) / k;
        return (v < 0) ? -r : r;
    endfunction

    function automatic longint unit_clamp(input longint v);
        if (v < 0) return 0;
        if (v > (longint'(1) << 30)) return longint'(1) << 30;
        return v;
    endfunction

    function automatic longint exp_frac(input longint f);
        longint sum;
        longint term;
        sum  = longint'(1) << 30;
        term = longint'(1) << 30;
        for (int k = 1; k <= 16; k++) begin
            term = -fix_div(fix_mul(term, f), k);
            sum += term;
        end
        return unit_clamp(sum);
    endfunction

    function automatic longint exp_of_square(input longint sq);
        longint s30;
        longint n;
        longint res;
        longint e1;
        if (sq >= (longint'(32) << (2 * IN_FB))) return 0;
        s30 = sq << (30 - 2 * IN_FB);
        n   = s30 >>> 30;
        res = exp_frac(s30 & ((longint'(1) << 30) - 1));
        e1  = exp_frac(longint'(1) << 30);
        for (longint i = 0; i < n; i++) res = fix_mul(res, e1);
        return res;
    endfunction

    function automatic logic [RES_W-1:0] erfc_of(input logic [ARG_W-1:0] arg);
        bit      neg;
        longint  mag;
        longint  den;
        longint  t;
        longint  acc;
        longint  y;
        longint  r;
        longint  res;
        neg = arg[ARG_W-1];
        mag = neg ? 65536 - longint'(arg) : longint'(arg);
        den = (longint'(1) << 30)
            + ((coef_fixed(327591100) * mag + (longint'(1) << (IN_FB - 1))) >>> IN_FB);
        t   = ((longint'(1) << 60) + den / 2) / den;
        acc = coef_fixed(1061405429);
        acc = fix_mul(acc, t) + coef_fixed(-1453152027);
        acc = fix_mul(acc, t) + coef_fixed(1421413741);
        acc = fix_mul(acc, t) + coef_fixed(-284496736);
        acc = fix_mul(acc, t) + coef_fixed(254829592);
        acc = unit_clamp(fix_mul(acc, t));
        y   = unit_clamp(fix_mul(acc, exp_of_square(mag * mag)));
        r   = neg ? (longint'(2) << 30) - y : y;
        res = (r + (longint'(1) << (29 - OUT_FB))) >>> (30 - OUT_FB);
        if (res > (longint'(2) << OUT_FB)) res = longint'(2) << OUT_FB;
        if (res > 65535) res = 65535;
        return res[RES_W-1:0];
    endfunction

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                if (arg_queue.size() > 0 && (calm_phase || $urandom_range(99) >= 20)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= arg_queue.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= calm_phase || ($urandom_range(99) >= 20);
        end
    end

    // scoreboard: predict on accepted input, compare on accepted output
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn && s_tvalid && s_tready) begin
            erfc_expected.push_back(erfc_of(s_tdata));
            words_sent++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (erfc_expected.size() == 0) begin
                $error("unexpected word: erfc_value actual %0d", m_tdata);
                error_count++;
            end else begin
                logic [RES_W-1:0] want;
                want = erfc_expected.pop_front();
                if (m_tdata !== want) begin
                    $error("erfc_value mismatch: expected %0d actual %0d", want, m_tdata);
                    error_count++;
                end
                words_checked++;
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [ARG_W-1:0] directed[$];
        directed = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8001,
                     16'h1000, 16'hF000, 16'h0800, 16'hF800, 16'h2000, 16'hE000,
                     16'h5A82, 16'hA57E, 16'h5A83, 16'h3000, 16'hD000, 16'h5555,
                     16'hAAAA, 16'h00FF, 16'hFF00, 16'h4000, 16'hC000};
        foreach (directed[i]) arg_queue.push_back(directed[i]);
        for (int i = 0; i < N_RANDOM; i++) begin
            case ($urandom_range(3))
                0:       arg_queue.push_back(16'($urandom_range(16'hFFFF)));
                1:       arg_queue.push_back(16'($signed($urandom_range(12288)) - 6144));
                default: arg_queue.push_back(16'($signed($urandom_range(24000)) - 12000));
            endcase
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        // idling free stretch
        wait (words_sent > 300);
        calm_phase = 1'b1;
        wait (words_sent > 600);
        calm_phase = 1'b0;
        wait (arg_queue.size() == 0 && !s_tvalid);
        wait (erfc_expected.size() == 0);
        repeat (LATENCY + 20) @(posedge aclk);
        $display("tb: sent %0d arguments, checked %0d erfc words", words_sent, words_checked);
        if (error_count == 0 && erfc_expected.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
